>>> rtl/sbad_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the system bus address decoder.
// No dependencies; every other file of the block takes names from here.
package sbad_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned REGION_W = 5;
  localparam int unsigned FOLD_W   = 29;
  localparam int unsigned SEG_W    = 3;
  localparam int unsigned NUM_WIN  = 16;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [REGION_W-1:0] region_t;
  typedef logic [FOLD_W-1:0]   fold_t;
  typedef logic [SEG_W-1:0]    seg_t;

  // Segment codes from the top three address bits.
  localparam seg_t SEG_CACHED   = 3'd0;
  localparam seg_t SEG_UNCACHED = 3'd1;
  localparam seg_t SEG_PURGE    = 3'd2;
  localparam seg_t SEG_ADDR_ARR = 3'd3;
  localparam seg_t SEG_ONCHIP   = 3'd7;

  // Region codes.
  localparam region_t REGION_PURGE    = 5'd16;
  localparam region_t REGION_ADDR_ARR = 5'd17;
  localparam region_t REGION_SDRAM    = 5'd18;
  localparam region_t REGION_ONCHIP   = 5'd19;
  localparam region_t REGION_NONE     = 5'd20;

  // Segment 3 and segment 7 limits.
  localparam fold_t ADDR_ARR_LIMIT = 29'h00003FF;
  localparam addr_t SDRAM_LO       = 32'hFFFF8000;
  localparam addr_t SDRAM_HI       = 32'hFFFFC000;
  localparam addr_t ONCHIP_LO      = 32'hFFFFFE00;
  localparam addr_t SDRAM_MASK     = 32'h00000FFF;
  localparam addr_t ONCHIP_MASK    = 32'h000001FF;

  // One window of the low segments: [lo, hi) on the folded address.
  typedef struct packed {
    fold_t   lo;
    fold_t   hi;
    fold_t   mask;
    region_t region;
  } window_t;

  typedef window_t window_tab_t [NUM_WIN];

  localparam window_tab_t WINDOWS = '{
    '{29'h0000000, 29'h0080000, 29'h1FFFFFFF, 5'd0},
    '{29'h0100000, 29'h0100080, 29'h00000FF, 5'd1},
    '{29'h0180000, 29'h0190000, 29'h000FFFF, 5'd2},
    '{29'h0200000, 29'h0300000, 29'h00FFFFF, 5'd3},
    '{29'h2000000, 29'h4000000, 29'h0FFFFFF, 5'd4},
    '{29'h4000000, 29'h5000000, 29'h0FFFFFF, 5'd5},
    '{29'h5800000, 29'h5900000, 29'h00FFFFF, 5'd6},
    '{29'h5A00000, 29'h5A80000, 29'h000FFFF, 5'd7},
    '{29'h5B00000, 29'h5B00EE4, 29'h0000FFF, 5'd8},
    '{29'h5C00000, 29'h5CC0000, 29'h00FFFFF, 5'd9},
    '{29'h5D00000, 29'h5D00018, 29'h00000FF, 5'd10},
    '{29'h5E00000, 29'h5E80000, 29'h00FFFFF, 5'd11},
    '{29'h5F00000, 29'h5F01000, 29'h000FFFF, 5'd12},
    '{29'h5F80000, 29'h5F80120, 29'h0000FFF, 5'd13},
    '{29'h5FE0000, 29'h5FE00D0, 29'h00000FF, 5'd14},
    '{29'h6000000, 29'h6100000, 29'h00FFFFF, 5'd15}
  };

endpackage

>>> rtl/sbad_addr_if.sv
`timescale 1ns / 1ps
// Request channel of the address decoder: one bus address per beat.
// Depends on sbad_pkg for the address type.
interface sbad_addr_if;
  logic           valid;
  logic           ready;
  sbad_pkg::addr_t address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

>>> rtl/sbad_result_if.sv
`timescale 1ns / 1ps
// Response channel of the address decoder: region, offset and error flag per beat.
// Depends on sbad_pkg for the field types.
interface sbad_result_if;
  logic             valid;
  logic             ready;
  sbad_pkg::region_t region;
  sbad_pkg::addr_t   offset;
  logic             bad_access;

  modport source (output valid, output region, output offset, output bad_access,
                  input ready);
  modport sink   (input valid, input region, input offset, input bad_access,
                  output ready);
endinterface

>>> rtl/system_bus_address_decoder.sv
`timescale 1ns / 1ps
// System bus address decoder: maps each 32-bit bus address beat to a target region
// and a local offset. Depends on sbad_pkg, sbad_addr_if and sbad_result_if.
//
// The decoder takes one address beat per clock unless stalled and returns exactly
// one response beat for it, in order. An accepted address is held in an input
// register; the decode is a single level of compares against fixed windows, and
// its answer is captured in the response register when that register can load,
// so each response is presented from a register. Both registers advance together
// whenever the response side is not stalled, which sustains one beat per cycle.
// When the response sink holds ready low, the pipeline stalls and request ready
// drops only once both the input and the response stages are full.
// The top three address bits select a segment. Segments 0 and 1 fold the address
// to 29 bits and look it up in sixteen windows (boot ROM through high RAM); the
// offset is the folded address under that window's mask. Segment 2 is the purge
// area and returns the whole address as offset. Segment 3 is the address array,
// valid for folded addresses below 0x3FF. Segment 7 holds the SDRAM mode window
// and the on-chip register page. Every other address returns region "none",
// offset zero and bad_access set; an unmatched address never falls into the
// decoding of a different segment. There is no configuration and no state beyond
// the pipeline registers.
module system_bus_address_decoder (
  input  logic          clk,
  input  logic          rst,
  sbad_addr_if.sink     request,
  sbad_result_if.source response
);

  // Input stage.
  logic             in_valid;
  sbad_pkg::addr_t  in_addr;

  // Response stage.
  logic              out_valid;
  sbad_pkg::region_t out_region;
  sbad_pkg::addr_t   out_offset;
  logic              out_bad;

  logic out_advance;
  logic in_advance;

  // The response register can load when it is empty or being drained; the input
  // register can load when it is empty or moving into the response register.
  assign out_advance   = !out_valid || response.ready;
  assign in_advance    = !in_valid || out_advance;
  assign request.ready = in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_advance) begin
      in_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && request.valid) begin
      in_addr <= request.address;
    end
  end

  // Decode of the held address.
  sbad_pkg::seg_t    seg;
  sbad_pkg::fold_t   folded;
  sbad_pkg::region_t region_next;
  sbad_pkg::addr_t   offset_next;
  logic              bad_next;
  logic              win_hit;
  sbad_pkg::region_t win_region;
  sbad_pkg::fold_t   win_offset;

  assign seg    = in_addr[sbad_pkg::ADDR_W-1 -: sbad_pkg::SEG_W];
  assign folded = in_addr[sbad_pkg::FOLD_W-1:0];

  // Windows never overlap, so at most one matches; the OR-merge picks it out.
  always_comb begin
    win_hit    = 1'b0;
    win_region = '0;
    win_offset = '0;
    for (int i = 0; i < sbad_pkg::NUM_WIN; i++) begin
      if (folded >= sbad_pkg::WINDOWS[i].lo && folded < sbad_pkg::WINDOWS[i].hi) begin
        win_hit    = 1'b1;
        win_region = win_region | sbad_pkg::WINDOWS[i].region;
        win_offset = win_offset | (folded & sbad_pkg::WINDOWS[i].mask);
      end
    end
  end

  always_comb begin
    region_next = sbad_pkg::REGION_NONE;
    offset_next = '0;
    bad_next    = 1'b1;
    case (seg)
      sbad_pkg::SEG_CACHED, sbad_pkg::SEG_UNCACHED: begin
        if (win_hit) begin
          region_next = win_region;
          offset_next = {{(sbad_pkg::ADDR_W-sbad_pkg::FOLD_W){1'b0}}, win_offset};
          bad_next    = 1'b0;
        end
      end
      sbad_pkg::SEG_PURGE: begin
        region_next = sbad_pkg::REGION_PURGE;
        offset_next = in_addr;
        bad_next    = 1'b0;
      end
      sbad_pkg::SEG_ADDR_ARR: begin
        if (folded < sbad_pkg::ADDR_ARR_LIMIT) begin
          region_next = sbad_pkg::REGION_ADDR_ARR;
          offset_next = {{(sbad_pkg::ADDR_W-sbad_pkg::FOLD_W){1'b0}}, folded};
          bad_next    = 1'b0;
        end
      end
      sbad_pkg::SEG_ONCHIP: begin
        if (in_addr >= sbad_pkg::SDRAM_LO && in_addr < sbad_pkg::SDRAM_HI) begin
          region_next = sbad_pkg::REGION_SDRAM;
          offset_next = in_addr & sbad_pkg::SDRAM_MASK;
          bad_next    = 1'b0;
        end else if (in_addr >= sbad_pkg::ONCHIP_LO) begin
          region_next = sbad_pkg::REGION_ONCHIP;
          offset_next = in_addr & sbad_pkg::ONCHIP_MASK;
          bad_next    = 1'b0;
        end
      end
      default: begin
        region_next = sbad_pkg::REGION_NONE;
        offset_next = '0;
        bad_next    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      out_region <= region_next;
      out_offset <= offset_next;
      out_bad    <= bad_next;
    end
  end

  assign response.valid      = out_valid;
  assign response.region     = out_region;
  assign response.offset     = out_offset;
  assign response.bad_access = out_bad;

endmodule
